// ===== hdl/shps_pkg.sv =====
// Shared types, constants and codes of the spline height profile sampler.
package shps_pkg;

	localparam int unsigned MAX_POINTS_DEF = 256;
	localparam int unsigned VAL_W = 32;
	localparam int unsigned ACC_W = 38;
	localparam int unsigned MUL_W = 56;
	localparam int unsigned NUM_W = 50;
	localparam int unsigned Q_W = 17;

	localparam logic [Q_W-1:0] ONE_Q16 = 17'h10000;
	localparam logic [Q_W-1:0] HALF_Q16 = 17'h08000;

	localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(2147483647);
	localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - ACC_W'(1);

	localparam logic REG_LOOP_DISTANCE = 1'b0;
	localparam logic REG_LOOP_SMOOTHING = 1'b1;

	typedef enum logic [1:0] {
		OP_SAMPLE = 2'd0,
		OP_APPEND = 2'd1,
		OP_CLEAR  = 2'd2,
		OP_NOP    = 2'd3
	} op_t;

	typedef enum logic [4:0] {
		CMD_NONE, CMD_LOAD, CMD_APPEND, CMD_CLEAR, CMD_SRCH_RD, CMD_SRCH_CMP,
		CMD_RD_A, CMD_RD_B, CMD_RD_C, CMD_RD_D, CMD_RD_E, CMD_RD_LAST, CMD_CAP_LAST,
		CMD_T_CAP, CMD_H_MUL, CMD_H_ADD, CMD_H_FIN, CMD_S_INIT, CMD_S_CAP,
		CMD_E_M1, CMD_E_M2, CMD_E_FIN, CMD_B_MUL, CMD_B_FIN
	} dp_cmd_t;

	typedef struct packed {
		dp_cmd_t cmd;
		logic    fin;
	} dp_ctl_t;

	typedef struct packed {
		logic trivial;
		logic ge;
		logic at_last;
		logic div_busy;
		logic h_last;
		logic in_win;
		logic smooth_zero;
	} dp_stat_t;

	typedef enum logic [4:0] {
		ST_IDLE, ST_SAMPLE, ST_SRCH_RD, ST_SRCH_CMP, ST_RD_A, ST_RD_B, ST_RD_C,
		ST_RD_D, ST_RD_E, ST_DIV_T, ST_H_MUL, ST_H_ADD, ST_H_FIN, ST_S_INIT,
		ST_DIV_S, ST_E_M1, ST_E_M2, ST_E_FIN, ST_B_MUL, ST_B_FIN, ST_LAST_RD,
		ST_LAST_CAP, ST_APPEND, ST_CLEAR
	} state_t;

endpackage

// ===== hdl/spline_height_profile_sampler.sv =====
// Top level of the spline height profile sampler: controller, datapath, checks.
//
//  Channel   Handshake              Payload
//  --------  ---------------------  -----------------------------------------------------
//  item in   start, busy            op, sample_distance, point_height, point_interval
//  result    done (one-cycle pulse) height_value, total_length, table_empty,
//                                   append_refused
//  config    cfg_we                 cfg_idx, cfg_wdata
//
// An item is accepted on a rising edge with start high and busy low, and the block works
// on one item at a time. A sample item that lands inside the table runs a linear search
// over the distance memory, then a restoring division for the segment parameter and,
// when it falls in the loop window with nonzero smoothing, a second one for the loop-window
// position; each division produces one quotient bit per cycle. A sample past the last point
// ends after the search with the height of the last point, and a sample on an empty table
// or at distance zero finishes without a search.
// The result is presented for exactly one cycle with done; the receiver cannot stall it.
// Reset is asynchronous and active low; the point memories need no clearing pass, since
// entry 0 is always read as zero and only entries below the point count are ever read.
module spline_height_profile_sampler
	import shps_pkg::*;
#(
	parameter int unsigned MAX_POINTS = MAX_POINTS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic [1:0]              op,
	input  logic [VAL_W-1:0]        sample_distance,
	input  logic signed [VAL_W-1:0] point_height,
	input  logic [VAL_W-1:0]        point_interval,
	input  logic                    cfg_we,
	input  logic                    cfg_idx,
	input  logic [VAL_W-1:0]        cfg_wdata,
	output logic                    done,
	output logic signed [VAL_W-1:0] height_value,
	output logic [VAL_W-1:0]        total_length,
	output logic                    table_empty,
	output logic                    append_refused
);

	dp_ctl_t  ctl;
	dp_stat_t stat;

	// The controller decodes the op code straight from the port in the accepting cycle.
	shps_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.op     (op_t'(op)),
		.stat   (stat),
		.ctl    (ctl),
		.busy   (busy)
	);

	// The datapath holds the point tables, the configuration registers, the divider
	// and the single shared multiplier used by the spline, ease and blend steps.
	shps_dp #(.MAX_POINTS(MAX_POINTS)) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.ctl             (ctl),
		.stat            (stat),
		.sample_distance (sample_distance),
		.point_height    (point_height),
		.point_interval  (point_interval),
		.cfg_we          (cfg_we),
		.cfg_idx         (cfg_idx),
		.cfg_wdata       (cfg_wdata),
		.done            (done),
		.height_value    (height_value),
		.total_length    (total_length),
		.table_empty     (table_empty),
		.append_refused  (append_refused)
	);

	// A result only follows an accepted item or work in progress.
	a_done_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(busy) || $past(start)))
		else $error("result strobe without an item in progress");

	// Work never ends without delivering its result.
	a_idle_with_result: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("item finished without a result");

	// An empty table always goes with a zero running length.
	a_empty_len_zero: assert property (@(posedge clk) disable iff (!arst_n)
		table_empty |-> (total_length == '0))
		else $error("empty table with nonzero running length");

	// A refused append is only possible on a table that holds points.
	a_refused_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(done && append_refused) |-> !table_empty)
		else $error("append refused on an empty table");

endmodule

// ===== hdl/shps_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module shps_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 256,
	localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== hdl/shps_div.sv =====
// Restoring divider that produces one quotient bit per cycle.
module shps_div
	import shps_pkg::*;
#(
	parameter int unsigned N_W = NUM_W,
	parameter int unsigned D_W = VAL_W
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [N_W-1:0] num,
	input  logic [D_W-1:0] den,
	output logic           busy,
	output logic [N_W-1:0] quo
);

	localparam int unsigned CNT_W = $clog2(N_W);

	logic [N_W-1:0]   n_q;
	logic [D_W-1:0]   d_q;
	logic [D_W-1:0]   r_q;
	logic [CNT_W-1:0] cnt_q;
	logic             run_q;
	logic [D_W:0]     rs;
	logic [D_W:0]     diff;
	logic             take;

	assign rs   = {r_q, n_q[N_W-1]};
	assign diff = rs - {1'b0, d_q};
	assign take = rs >= {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			run_q <= 1'b1;
			cnt_q <= '0;
		end else if (run_q) begin
			cnt_q <= cnt_q + CNT_W'(1);
			if (cnt_q == CNT_W'(N_W - 1)) begin
				run_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q <= num;
			d_q <= den;
			r_q <= '0;
		end else if (run_q) begin
			r_q <= take ? diff[D_W-1:0] : rs[D_W-1:0];
			n_q <= {n_q[N_W-2:0], take};
		end
	end

	assign busy = run_q;
	assign quo  = n_q;

endmodule

// ===== hdl/shps_ctrl.sv =====
// Controller state machine that sequences the sampler datapath.
module shps_ctrl
	import shps_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  op_t      op,
	input  dp_stat_t stat,
	output dp_ctl_t  ctl,
	output logic     busy
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		ctl.cmd = CMD_NONE;
		ctl.fin = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					ctl.cmd = CMD_LOAD;
					case (op)
						OP_SAMPLE: state_d = ST_SAMPLE;
						OP_APPEND: state_d = ST_APPEND;
						OP_CLEAR:  state_d = ST_CLEAR;
						default:   ctl.fin = 1'b1;
					endcase
				end
			end
			ST_SAMPLE: begin
				if (stat.trivial) begin
					ctl.fin = 1'b1;
					state_d = ST_IDLE;
				end else begin
					state_d = ST_SRCH_RD;
				end
			end
			ST_SRCH_RD: begin
				ctl.cmd = CMD_SRCH_RD;
				state_d = ST_SRCH_CMP;
			end
			ST_SRCH_CMP: begin
				ctl.cmd = CMD_SRCH_CMP;
				if (stat.ge) begin
					state_d = ST_RD_A;
				end else if (stat.at_last) begin
					state_d = ST_LAST_RD;
				end else begin
					state_d = ST_SRCH_RD;
				end
			end
			ST_RD_A: begin
				ctl.cmd = CMD_RD_A;
				state_d = ST_RD_B;
			end
			ST_RD_B: begin
				ctl.cmd = CMD_RD_B;
				state_d = ST_RD_C;
			end
			ST_RD_C: begin
				ctl.cmd = CMD_RD_C;
				state_d = ST_RD_D;
			end
			ST_RD_D: begin
				ctl.cmd = CMD_RD_D;
				state_d = ST_RD_E;
			end
			ST_RD_E: begin
				ctl.cmd = CMD_RD_E;
				state_d = ST_DIV_T;
			end
			ST_DIV_T: begin
				if (!stat.div_busy) begin
					ctl.cmd = CMD_T_CAP;
					state_d = ST_H_MUL;
				end
			end
			ST_H_MUL: begin
				ctl.cmd = CMD_H_MUL;
				state_d = ST_H_ADD;
			end
			ST_H_ADD: begin
				ctl.cmd = CMD_H_ADD;
				state_d = stat.h_last ? ST_H_FIN : ST_H_MUL;
			end
			ST_H_FIN: begin
				ctl.cmd = CMD_H_FIN;
				if (!stat.in_win || stat.smooth_zero) begin
					ctl.fin = 1'b1;
					state_d = ST_IDLE;
				end else begin
					state_d = ST_S_INIT;
				end
			end
			ST_S_INIT: begin
				ctl.cmd = CMD_S_INIT;
				state_d = ST_DIV_S;
			end
			ST_DIV_S: begin
				if (!stat.div_busy) begin
					ctl.cmd = CMD_S_CAP;
					state_d = ST_E_M1;
				end
			end
			ST_E_M1: begin
				ctl.cmd = CMD_E_M1;
				state_d = ST_E_M2;
			end
			ST_E_M2: begin
				ctl.cmd = CMD_E_M2;
				state_d = ST_E_FIN;
			end
			ST_E_FIN: begin
				ctl.cmd = CMD_E_FIN;
				state_d = ST_B_MUL;
			end
			ST_B_MUL: begin
				ctl.cmd = CMD_B_MUL;
				state_d = ST_B_FIN;
			end
			ST_B_FIN: begin
				ctl.cmd = CMD_B_FIN;
				ctl.fin = 1'b1;
				state_d = ST_IDLE;
			end
			ST_LAST_RD: begin
				ctl.cmd = CMD_RD_LAST;
				state_d = ST_LAST_CAP;
			end
			ST_LAST_CAP: begin
				ctl.cmd = CMD_CAP_LAST;
				ctl.fin = 1'b1;
				state_d = ST_IDLE;
			end
			ST_APPEND: begin
				ctl.cmd = CMD_APPEND;
				ctl.fin = 1'b1;
				state_d = ST_IDLE;
			end
			ST_CLEAR: begin
				ctl.cmd = CMD_CLEAR;
				ctl.fin = 1'b1;
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign busy = (state_q != ST_IDLE);

endmodule

// ===== hdl/shps_dp.sv =====
// Datapath: point tables, search index, divider, shared multiplier and result.
module shps_dp
	import shps_pkg::*;
#(
	parameter int unsigned MAX_POINTS = MAX_POINTS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  dp_ctl_t                 ctl,
	output dp_stat_t                stat,
	input  logic [VAL_W-1:0]        sample_distance,
	input  logic signed [VAL_W-1:0] point_height,
	input  logic [VAL_W-1:0]        point_interval,
	input  logic                    cfg_we,
	input  logic                    cfg_idx,
	input  logic [VAL_W-1:0]        cfg_wdata,
	output logic                    done,
	output logic signed [VAL_W-1:0] height_value,
	output logic [VAL_W-1:0]        total_length,
	output logic                    table_empty,
	output logic                    append_refused
);

	localparam int unsigned AW = $clog2(MAX_POINTS);
	localparam int unsigned CW = $clog2(MAX_POINTS + 1);

	// Configuration and table state.
	logic [VAL_W-1:0] loop_q;
	logic [VAL_W-1:0] smooth_q;
	logic [CW-1:0]    count_q;
	logic [VAL_W-1:0] len_q;

	// Item and working registers.
	logic [VAL_W-1:0]        d_q;
	logic signed [VAL_W-1:0] hin_q;
	logic [VAL_W-1:0]        iv_q;
	logic [AW-1:0]           j_q;
	logic [VAL_W-1:0]        dhi_q;
	logic [VAL_W-1:0]        di_q;
	logic signed [VAL_W-1:0] p0_q, p1_q, p2_q, p3_q;
	logic [Q_W-1:0]          t_q;
	logic [Q_W-1:0]          s_q;
	logic [Q_W-1:0]          f_q;
	logic signed [ACC_W-1:0] acc_q;
	logic [1:0]              hs_q;
	logic signed [VAL_W-1:0] h_q;
	logic signed [MUL_W-1:0] mul_q;
	logic signed [VAL_W-1:0] res_q;
	logic                    refused_q;
	logic                    done_q;

	// Memory ports.
	logic                    wr_en;
	logic [AW-1:0]           dist_raddr;
	logic [AW-1:0]           hgt_raddr;
	logic [VAL_W-1:0]        dist_rd;
	logic [VAL_W-1:0]        hgt_rd;
	logic [VAL_W:0]          len_sum;
	logic [VAL_W-1:0]        len_sat;

	// Index arithmetic.
	logic [CW-1:0] last;
	logic [AW-1:0] idx_i;
	logic [AW-1:0] idx_im;
	logic [AW-1:0] idx_ip;
	logic [CW-1:0] i_plus2;
	logic          i_zero;
	logic          i_le1;

	// Divider.
	logic             div_start;
	logic [NUM_W-1:0] div_num;
	logic [VAL_W-1:0] div_den;
	logic             div_busy;
	logic [NUM_W-1:0] div_quo;
	logic [Q_W-1:0]   quo_clamp;
	logic [VAL_W-1:0] seg_w;
	logic [NUM_W-1:0] num_t;
	logic [NUM_W-1:0] num_s;

	// Loop window.
	logic signed [VAL_W+1:0] win_start;
	logic signed [VAL_W+1:0] d_ext;
	logic signed [VAL_W+1:0] d_off;
	logic                    in_win;

	// Spline coefficients.
	logic signed [ACC_W-1:0] e0, e1, e2, e3;
	logic signed [ACC_W-1:0] c0, c1, c2, c3;
	logic signed [ACC_W-1:0] c_sel;
	logic signed [ACC_W-1:0] half;
	logic signed [VAL_W-1:0] h_sat;

	// Shared multiplier and ease.
	logic signed [ACC_W-1:0] mul_a;
	logic signed [Q_W:0]     mul_b;
	logic                    ease_hi;
	logic [Q_W-1:0]          ease_diff;
	logic [Q_W-1:0]          ease_base;
	logic [48:0]             cube;

	shps_ram #(.WIDTH(VAL_W), .DEPTH(MAX_POINTS)) u_dist_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (count_q[AW-1:0]),
		.wdata (len_sat),
		.raddr (dist_raddr),
		.rdata (dist_rd)
	);

	shps_ram #(.WIDTH(VAL_W), .DEPTH(MAX_POINTS)) u_hgt_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (count_q[AW-1:0]),
		.wdata (hin_q),
		.raddr (hgt_raddr),
		.rdata (hgt_rd)
	);

	shps_div #(.N_W(NUM_W), .D_W(VAL_W)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.busy   (div_busy),
		.quo    (div_quo)
	);

	assign len_sum = {1'b0, len_q} + {1'b0, iv_q};
	assign len_sat = len_sum[VAL_W] ? '1 : len_sum[VAL_W-1:0];
	assign wr_en   = (ctl.cmd == CMD_APPEND) && (count_q < CW'(MAX_POINTS));

	assign last    = count_q - CW'(1);
	assign idx_i   = j_q - AW'(1);
	assign i_zero  = (idx_i == '0);
	assign i_le1   = (idx_i <= AW'(1));
	assign idx_im  = i_zero ? '0 : idx_i - AW'(1);
	assign i_plus2 = CW'(idx_i) + CW'(2);
	assign idx_ip  = (i_plus2 > last) ? last[AW-1:0] : i_plus2[AW-1:0];

	always_comb begin
		dist_raddr = j_q;
		hgt_raddr  = j_q;
		case (ctl.cmd)
			CMD_RD_A: begin
				dist_raddr = idx_i;
				hgt_raddr  = idx_im;
			end
			CMD_RD_B:    hgt_raddr = idx_i;
			CMD_RD_C:    hgt_raddr = j_q;
			CMD_RD_D:    hgt_raddr = idx_ip;
			CMD_RD_LAST: hgt_raddr = last[AW-1:0];
			default:     hgt_raddr = j_q;
		endcase
	end

	// The segment width is never zero after a successful search; one guards it anyway.
	assign seg_w     = dhi_q - di_q;
	assign num_t     = {2'b00, d_q - di_q, 16'h0000};
	assign win_start = $signed({2'b00, loop_q}) - $signed({2'b00, smooth_q});
	assign d_ext     = $signed({2'b00, d_q});
	assign in_win    = d_ext > win_start;
	assign d_off     = d_ext - win_start;
	assign num_s     = {d_off, 16'h0000};
	assign div_start = (ctl.cmd == CMD_RD_E) || (ctl.cmd == CMD_S_INIT);
	assign div_num   = (ctl.cmd == CMD_S_INIT) ? num_s : num_t;
	assign div_den   = (ctl.cmd == CMD_S_INIT) ? smooth_q :
	                   ((seg_w == '0) ? VAL_W'(1) : seg_w);
	assign quo_clamp = (div_quo > NUM_W'(ONE_Q16)) ? ONE_Q16 : div_quo[Q_W-1:0];

	assign e0 = ACC_W'(p0_q);
	assign e1 = ACC_W'(p1_q);
	assign e2 = ACC_W'(p2_q);
	assign e3 = ACC_W'(p3_q);
	assign c0 = e1 <<< 1;
	assign c1 = e2 - e0;
	assign c2 = (e0 <<< 1) - ((e1 <<< 2) + e1) + (e2 <<< 2) - e3;
	assign c3 = ((e1 <<< 1) + e1) - ((e2 <<< 1) + e2) + e3 - e0;

	always_comb begin
		case (hs_q)
			2'd0:    c_sel = c2;
			2'd1:    c_sel = c1;
			default: c_sel = c0;
		endcase
	end

	assign half  = acc_q >>> 1;
	assign h_sat = (half > SAT_HI) ? 32'sh7FFFFFFF :
	               (half < SAT_LO) ? 32'sh80000000 : half[VAL_W-1:0];

	assign ease_hi   = (s_q >= HALF_Q16);
	assign ease_diff = ONE_Q16 - s_q;
	assign ease_base = ease_hi ? {ease_diff[Q_W-2:0], 1'b0} : s_q;
	assign cube      = mul_q[48:0];

	always_comb begin
		case (ctl.cmd)
			CMD_E_M1: begin
				mul_a = ACC_W'(ease_base);
				mul_b = $signed({1'b0, ease_base});
			end
			CMD_E_M2: begin
				mul_a = ACC_W'(mul_q[32:0]);
				mul_b = $signed({1'b0, ease_base});
			end
			CMD_B_MUL: begin
				mul_a = ACC_W'(h_q);
				mul_b = $signed({1'b0, f_q});
			end
			default: begin
				mul_a = acc_q;
				mul_b = $signed({1'b0, t_q});
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loop_q   <= '1;
			smooth_q <= '0;
		end else if (cfg_we) begin
			if (cfg_idx == REG_LOOP_DISTANCE) begin
				loop_q <= cfg_wdata;
			end else begin
				smooth_q <= cfg_wdata;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= CW'(1);
			len_q     <= '0;
			done_q    <= 1'b0;
			refused_q <= 1'b0;
		end else begin
			done_q <= ctl.fin;
			case (ctl.cmd)
				CMD_LOAD: refused_q <= 1'b0;
				CMD_APPEND: begin
					if (wr_en) begin
						len_q   <= len_sat;
						count_q <= count_q + CW'(1);
					end else begin
						refused_q <= 1'b1;
					end
				end
				CMD_CLEAR: begin
					count_q <= CW'(1);
					len_q   <= '0;
				end
				default: begin
					len_q <= len_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (ctl.cmd)
			CMD_LOAD: begin
				d_q   <= sample_distance;
				hin_q <= point_height;
				iv_q  <= point_interval;
				j_q   <= AW'(1);
				res_q <= '0;
			end
			CMD_SRCH_CMP: begin
				dhi_q <= dist_rd;
				if (!stat.ge && !stat.at_last) begin
					j_q <= j_q + AW'(1);
				end
			end
			CMD_RD_B: begin
				di_q <= i_zero ? '0 : dist_rd;
				p0_q <= i_le1 ? '0 : $signed(hgt_rd);
			end
			CMD_RD_C:     p1_q <= i_zero ? '0 : $signed(hgt_rd);
			CMD_RD_D:     p2_q <= $signed(hgt_rd);
			CMD_RD_E:     p3_q <= $signed(hgt_rd);
			CMD_CAP_LAST: res_q <= $signed(hgt_rd);
			CMD_T_CAP: begin
				t_q   <= quo_clamp;
				acc_q <= c3;
				hs_q  <= 2'd0;
			end
			CMD_H_MUL, CMD_E_M1, CMD_E_M2, CMD_B_MUL: mul_q <= mul_a * mul_b;
			CMD_H_ADD: begin
				acc_q <= ACC_W'(mul_q >>> 16) + c_sel;
				hs_q  <= hs_q + 2'd1;
			end
			CMD_H_FIN: begin
				h_q   <= h_sat;
				res_q <= in_win ? '0 : h_sat;
			end
			CMD_S_CAP: s_q <= quo_clamp;
			CMD_E_FIN: begin
				f_q <= ease_hi ? Q_W'(cube >> 33) : ONE_Q16 - Q_W'(cube >> 30);
			end
			CMD_B_FIN: res_q <= mul_q[47:16];
			default: begin
				res_q <= res_q;
			end
		endcase
	end

	assign stat.trivial     = (count_q <= CW'(1)) || (d_q == '0);
	assign stat.ge          = (dist_rd >= d_q);
	assign stat.at_last     = (CW'(j_q) == last);
	assign stat.div_busy    = div_busy;
	assign stat.h_last      = (hs_q == 2'd2);
	assign stat.in_win      = in_win;
	assign stat.smooth_zero = (smooth_q == '0);

	assign done           = done_q;
	assign height_value   = res_q;
	assign total_length   = len_q;
	assign table_empty    = (count_q <= CW'(1));
	assign append_refused = refused_q;

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench of the spline height profile sampler, with its own predictor.
module tb_top;
	import shps_pkg::*;

	// Upper bound on clock cycles for the whole run.
	localparam longint unsigned CYCLE_LIMIT = 64'd5_000_000;
	localparam int unsigned NPTS = MAX_POINTS_DEF;

	typedef struct {
		op_t                op;
		logic signed [31:0] height;
		logic [31:0]        length;
		logic               empty;
		logic               refused;
	} profile_result_t;

	// Scoreboard: it mirrors the point table and the loop registers, and keeps the
	// results that accepted items are still owed, oldest first.
	class profile_scoreboard;
		logic [31:0]        loop_dist;
		logic [31:0]        loop_smooth;
		logic [31:0]        pt_dist [NPTS];
		logic signed [31:0] pt_hgt [NPTS];
		int unsigned        count;
		logic [31:0]        run_len;
		profile_result_t    owed [$];

		function new();
			loop_dist = 32'hFFFF_FFFF;
			loop_smooth = 32'd0;
			pt_dist[0] = 32'd0;
			pt_hgt[0] = 32'sd0;
			count = 1;
			run_len = 32'd0;
		endfunction

		function void write_reg(logic idx, logic [31:0] val);
			if (idx == REG_LOOP_DISTANCE)
				loop_dist = val;
			else
				loop_smooth = val;
		endfunction

		function logic signed [31:0] clamp32(longint v);
			if (v > 64'sd2147483647)
				return 32'sh7FFF_FFFF;
			if (v < -64'sd2147483648)
				return 32'sh8000_0000;
			return v[31:0];
		endfunction

		// Uniform Catmull-Rom in Horner form; each step with t floors after the shift.
		function logic signed [31:0] spline(longint t, longint p0, longint p1, longint p2,
				longint p3);
			longint acc;
			acc = -p0 + 3 * p1 - 3 * p2 + p3;
			acc = ((acc * t) >>> 16) + (2 * p0 - 5 * p1 + 4 * p2 - p3);
			acc = ((acc * t) >>> 16) + (p2 - p0);
			acc = ((acc * t) >>> 16) + 2 * p1;
			return clamp32(acc >>> 1);
		endfunction

		function logic signed [31:0] sample_height(logic [31:0] d);
			int unsigned last;
			int unsigned im;
			int unsigned ip;
			longint width;
			longint t;
			longint s;
			longint u;
			longint e;
			longint start_pt;
			longint h;
			if (count <= 1 || d == 32'd0)
				return 32'sd0;
			last = count - 1;
			for (int unsigned i = 0; i < last; i++) begin
				if (pt_dist[i+1] >= d) begin
					im = (i == 0) ? 0 : i - 1;
					ip = (i + 2 > last) ? last : i + 2;
					width = longint'(pt_dist[i+1]) - longint'(pt_dist[i]);
					if (width == 0)
						width = 1;
					t = ((longint'(d) - longint'(pt_dist[i])) <<< 16) / width;
					if (t > 65536)
						t = 65536;
					h = spline(t, pt_hgt[im], pt_hgt[i], pt_hgt[i+1], pt_hgt[ip]);
					start_pt = longint'(loop_dist) - longint'(loop_smooth);
					if (longint'(d) > start_pt) begin
						if (loop_smooth == 32'd0)
							return 32'sd0;
						s = ((longint'(d) - start_pt) <<< 16) / longint'(loop_smooth);
						if (s > 65536)
							s = 65536;
						if (s < 32768) begin
							e = (s * s * s) >> 30;
						end else begin
							u = 2 * (65536 - s);
							e = 65536 - ((u * u * u) >> 33);
						end
						return clamp32((h * (65536 - e)) >>> 16);
					end
					return h[31:0];
				end
			end
			return pt_hgt[last];
		endfunction

		// Called for every accepted item: updates the table and queues the result.
		function void note_item(op_t op, logic [31:0] sd, logic signed [31:0] ph,
				logic [31:0] pi);
			profile_result_t r;
			longint unsigned sum;
			r.op = op;
			r.height = 32'sd0;
			r.refused = 1'b0;
			case (op)
				OP_SAMPLE: r.height = sample_height(sd);
				OP_APPEND: begin
					if (count >= NPTS) begin
						r.refused = 1'b1;
					end else begin
						sum = longint'(run_len) + longint'(pi);
						run_len = (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
						pt_dist[count] = run_len;
						pt_hgt[count] = ph;
						count++;
					end
				end
				OP_CLEAR: begin
					count = 1;
					run_len = 32'd0;
				end
				default: ;
			endcase
			r.length = run_len;
			r.empty = (count <= 1);
			owed.push_back(r);
		endfunction

		// Returns an empty string when the result matches the oldest owed one.
		function string check_result(logic signed [31:0] h, logic [31:0] len, logic emp,
				logic ref_flag);
			profile_result_t x;
			string msg;
			if (owed.size() == 0)
				return "result with nothing outstanding";
			x = owed.pop_front();
			msg = "";
			if (h !== x.height)
				msg = {msg, $sformatf(" height %h want %h", h, x.height)};
			if (len !== x.length)
				msg = {msg, $sformatf(" length %h want %h", len, x.length)};
			if (emp !== x.empty)
				msg = {msg, $sformatf(" empty %b want %b", emp, x.empty)};
			if (ref_flag !== x.refused)
				msg = {msg, $sformatf(" refused %b want %b", ref_flag, x.refused)};
			if (msg != "")
				msg = {x.op.name(), msg};
			return msg;
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic [1:0]         op;
	logic [31:0]        sample_distance;
	logic signed [31:0] point_height;
	logic [31:0]        point_interval;
	logic               cfg_we;
	logic               cfg_idx;
	logic [31:0]        cfg_wdata;
	logic               done;
	logic signed [31:0] height_value;
	logic [31:0]        total_length;
	logic               table_empty;
	logic               append_refused;

	spline_height_profile_sampler dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.op             (op),
		.sample_distance(sample_distance),
		.point_height   (point_height),
		.point_interval (point_interval),
		.cfg_we         (cfg_we),
		.cfg_idx        (cfg_idx),
		.cfg_wdata      (cfg_wdata),
		.done           (done),
		.height_value   (height_value),
		.total_length   (total_length),
		.table_empty    (table_empty),
		.append_refused (append_refused)
	);

	profile_scoreboard sb;
	int unsigned       err_count;
	int unsigned       taken_items;
	longint unsigned   cycles;
	bit                no_gaps;

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	task automatic report(string what);
		err_count++;
		$display("mismatch at cycle %0d: %s", cycles, what);
	endtask

	// Inputs change on the falling edge, so at the rising edge these reads see the
	// values the block itself samples, whatever the order of processes in the step.
	always @(posedge clk) begin
		string msg;
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_top: errors");
			$finish;
		end else begin
			if (arst_n && start && !busy) begin
				sb.note_item(op_t'(op), sample_distance, point_height, point_interval);
				taken_items++;
			end
			if (arst_n && done) begin
				msg = sb.check_result(height_value, total_length, table_empty,
					append_refused);
				if (msg != "")
					report(msg);
			end
		end
	end

	// Most gaps are short; a few are long, and some stretches have none at all.
	function automatic int unsigned pick_gap();
		int unsigned r;
		if (no_gaps)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Presents one item and returns at the falling edge after it was taken. Start stays
	// high there, so a following item without a gap goes back to back.
	task automatic send_item(op_t o, logic [31:0] sd, logic signed [31:0] ph,
			logic [31:0] pi);
		int unsigned gap;
		int unsigned seen;
		gap = pick_gap();
		if (gap > 0) begin
			start = 1'b0;
			repeat (gap) @(negedge clk);
		end
		op = o;
		sample_distance = sd;
		point_height = ph;
		point_interval = pi;
		start = 1'b1;
		seen = taken_items;
		do
			@(negedge clk);
		while (taken_items == seen);
	endtask

	task automatic wait_idle();
		start = 1'b0;
		@(negedge clk);
		while (sb.owed.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// Registers are written only with nothing outstanding.
	task automatic set_loop(logic [31:0] loop_len, logic [31:0] smooth);
		wait_idle();
		cfg_we = 1'b1;
		cfg_idx = REG_LOOP_DISTANCE;
		cfg_wdata = loop_len;
		@(negedge clk);
		sb.write_reg(REG_LOOP_DISTANCE, loop_len);
		cfg_idx = REG_LOOP_SMOOTHING;
		cfg_wdata = smooth;
		@(negedge clk);
		sb.write_reg(REG_LOOP_SMOOTHING, smooth);
		cfg_we = 1'b0;
		@(negedge clk);
	endtask

	function automatic logic [31:0] pick_height();
		case ($urandom_range(0, 5))
			0: return $urandom();
			1: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
			default: return 32'($signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000);
		endcase
	endfunction

	function automatic logic [31:0] pick_interval();
		case ($urandom_range(0, 19))
			0: return 32'd0;
			1: return $urandom();
			2: return 32'hFFFF_FFFF;
			default: return $urandom_range(1, 32'h0004_0000);
		endcase
	endfunction

	// Sample distances aimed at points, segments, the loop window and the far end.
	function automatic logic [31:0] pick_distance();
		logic [31:0] pd;
		pd = sb.pt_dist[$urandom_range(0, sb.count - 1)];
		case ($urandom_range(0, 11))
			0: return 32'd0;
			1: return $urandom();
			2: return pd;
			3: return pd + 32'd1;
			4: return pd - 32'd1;
			5: return sb.run_len + $urandom_range(1, 32'h0002_0000);
			6: return sb.loop_dist - $urandom_range(0, 32'h0002_0000);
			7: return sb.loop_dist + $urandom_range(0, 32'h0001_0000);
			default: return $urandom_range(1, (sb.run_len == 0) ? 1 : sb.run_len);
		endcase
	endfunction

	// A table of a few points, then samples over it, with some noise mixed in.
	task automatic random_batch(inout int unsigned n);
		int unsigned pts;
		int unsigned k;
		if ($urandom_range(0, 3) != 0) begin
			send_item(OP_CLEAR, $urandom(), $urandom(), $urandom());
			n++;
		end
		pts = $urandom_range(0, 9);
		for (int unsigned i = 0; i < pts; i++) begin
			send_item(OP_APPEND, $urandom(), pick_height(), pick_interval());
			n++;
		end
		k = $urandom_range(2, 12);
		for (int unsigned i = 0; i < k; i++) begin
			case ($urandom_range(0, 19))
				0: send_item(OP_NOP, $urandom(), $urandom(), $urandom());
				1: send_item(OP_APPEND, $urandom(), pick_height(), pick_interval());
				default: send_item(OP_SAMPLE, pick_distance(), $urandom(), $urandom());
			endcase
			n++;
		end
		if ($urandom_range(0, 7) == 0)
			no_gaps = !no_gaps;
	endtask

	// Fills the table to its last entry, samples a deep table, then tries to overfill.
	task automatic fill_table(inout int unsigned n);
		send_item(OP_CLEAR, 32'd0, 32'sd0, 32'd0);
		n++;
		for (int unsigned i = 1; i < NPTS; i++) begin
			send_item(OP_APPEND, $urandom(), pick_height(), $urandom_range(0, 32'h0000_4000));
			n++;
		end
		for (int unsigned i = 0; i < 6; i++) begin
			send_item(OP_SAMPLE, pick_distance(), $urandom(), $urandom());
			n++;
		end
		for (int unsigned i = 0; i < 3; i++) begin
			send_item(OP_APPEND, $urandom(), $urandom(), $urandom());
			n++;
		end
		send_item(OP_SAMPLE, sb.run_len + 32'd1, 32'sd0, 32'd0);
		send_item(OP_CLEAR, 32'd0, 32'sd0, 32'd0);
		n += 2;
	endtask

	initial begin
		int unsigned n;
		logic [31:0] dists [6];
		logic [31:0] smooths [6];
		sb = new();
		err_count = 0;
		taken_items = 0;
		cycles = 0;
		no_gaps = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		op = OP_NOP;
		sample_distance = 32'd0;
		point_height = 32'sd0;
		point_interval = 32'd0;
		cfg_we = 1'b0;
		cfg_idx = REG_LOOP_DISTANCE;
		cfg_wdata = 32'd0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed part under the reset loop settings: empty table, extreme heights,
		// a zero interval, exact point hits, past the end, clear, length saturation.
		send_item(OP_SAMPLE, 32'd5, 32'sd0, 32'd0);
		send_item(OP_APPEND, 32'd0, 32'sh7FFF_FFFF, 32'h0001_0000);
		send_item(OP_APPEND, 32'd0, 32'sh8000_0000, 32'h0001_0000);
		send_item(OP_APPEND, 32'd0, 32'sd0, 32'd0);
		send_item(OP_APPEND, 32'd0, 32'sh1234_5678, 32'h0000_8000);
		send_item(OP_SAMPLE, 32'd0, 32'sd0, 32'd0);
		send_item(OP_SAMPLE, 32'd1, 32'sd0, 32'd0);
		send_item(OP_SAMPLE, 32'h0001_0000, 32'sd0, 32'd0);
		send_item(OP_SAMPLE, 32'h0001_8000, 32'sd0, 32'd0);
		send_item(OP_SAMPLE, 32'h0002_8000, 32'sd0, 32'd0);
		send_item(OP_SAMPLE, 32'h0002_8001, 32'sd0, 32'd0);
		send_item(OP_SAMPLE, 32'hFFFF_FFFF, 32'sd0, 32'd0);
		send_item(OP_NOP, 32'hFFFF_FFFF, 32'shFFFF_FFFF, 32'hFFFF_FFFF);
		send_item(OP_CLEAR, 32'hFFFF_FFFF, 32'shFFFF_FFFF, 32'hFFFF_FFFF);
		send_item(OP_SAMPLE, 32'h0001_0000, 32'sd0, 32'd0);
		send_item(OP_APPEND, 32'd0, 32'sh0001_0000, 32'hFFFF_FFFF);
		send_item(OP_APPEND, 32'd0, -32'sh0001_0000, 32'hFFFF_FFFF);
		send_item(OP_SAMPLE, 32'h8000_0000, 32'sd0, 32'd0);
		send_item(OP_SAMPLE, 32'hFFFF_FFFF, 32'sd0, 32'd0);
		send_item(OP_CLEAR, 32'd0, 32'sd0, 32'd0);

		// Loop settings per phase: a window inside the table, a window that starts
		// below zero, zero smoothing, everything zero, both at maximum, and reset values.
		dists = '{32'h0010_0000, 32'h0004_0000, 32'h0008_0000, 32'd0, 32'hFFFF_FFFF,
			32'hFFFF_FFFF};
		smooths = '{32'h0008_0000, 32'h0020_0000, 32'd0, 32'd0, 32'hFFFF_FFFF, 32'd0};
		for (int p = 0; p < 6; p++) begin
			// Changing the registers also waits out every outstanding result.
			set_loop(dists[p], smooths[p]);
			n = 0;
			if (p == 2)
				fill_table(n);
			while (n < 150)
				random_batch(n);
		end

		wait_idle();
		repeat (20) @(negedge clk);
		if (err_count == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

endmodule
